// ----- rtl/core/ipd_pkg.sv -----
// ----------------------------------------------------------------------------
// ipd_pkg
// Shared types and constants for the integer power unit.
// ----------------------------------------------------------------------------
package ipd_pkg;

    localparam int DBL_W  = 64;
    localparam int MANT_W = 53;
    localparam int FRAC_W = 52;
    localparam int HALF_W = 27;
    localparam int PROD_W = 106;
    localparam int EXP_W  = 14;
    localparam int MAG_W  = 31;
    localparam int LZ_W   = 7;
    localparam int CNT_W  = 6;
    localparam int REM_W  = 54;

    localparam logic [DBL_W-1:0] ONE_BITS  = 64'h3FF0_0000_0000_0000;
    localparam logic [DBL_W-1:0] ZERO_BITS = 64'h0000_0000_0000_0000;
    localparam logic [DBL_W-1:0] DFLT_NAN  = 64'hFFF8_0000_0000_0000;
    localparam logic [10:0]      EXP_MAX   = 11'h7FF;
    localparam logic [10:0]      EXP_BIAS  = 11'd1023;
    localparam logic [10:0]      EXP_LIMIT = 11'd1054;   // 2^31
    localparam int               QUIET_BIT = 51;
    localparam logic [CNT_W-1:0] DIV_LAST  = 6'd55;      // 56 quotient bits
    localparam logic [1:0]       PP_LAST   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_SQR_ISSUE,
        ST_SQR,
        ST_RECIP,
        ST_FINISH
    } ctrl_state_t;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_PP,
        FS_DNORM,
        FS_DIV,
        FS_LZC,
        FS_RND,
        FS_DONE
    } fpu_state_t;

    typedef enum logic {
        OP_MUL,
        OP_RECIP
    } fpu_op_t;

    typedef struct packed {
        logic    load;
        logic    fpu_start;
        fpu_op_t fpu_op;
        logic    sel_sqr;
        logic    wr_acc;
        logic    wr_base;
        logic    shift_mag;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic special;
        logic neg;
        logic mag_zero;
        logic mag_bit0;
        logic mag_last;
        logic fpu_done;
    } dp_status_t;

    function automatic logic is_nan(input logic [DBL_W-1:0] x);
        return (x[62:52] == EXP_MAX) && (x[51:0] != '0);
    endfunction

    function automatic logic is_inf(input logic [DBL_W-1:0] x);
        return (x[62:52] == EXP_MAX) && (x[51:0] == '0);
    endfunction

    function automatic logic is_zero(input logic [DBL_W-1:0] x);
        return x[62:0] == '0;
    endfunction

endpackage

// ----- rtl/core/ipd_fpu.sv -----
// ----------------------------------------------------------------------------
// ipd_fpu
// Multi-cycle double multiplier and reciprocal with a shared normalize and
// round-to-nearest-even back end.
// ----------------------------------------------------------------------------
module ipd_fpu
    import ipd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  fpu_op_t          op,
    input  logic [DBL_W-1:0] a,
    input  logic [DBL_W-1:0] b,
    output logic             done,
    output logic [DBL_W-1:0] result
);

    fpu_state_t              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    sign_reg, sign_next;
    logic signed [EXP_W-1:0] esum_reg, esum_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic                    stk_reg, stk_next;
    logic [MANT_W-1:0]       ma_reg, ma_next;
    logic [MANT_W-1:0]       mb_reg, mb_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [LZ_W-1:0]         lz_reg, lz_next;
    logic [DBL_W-1:0]        res_reg, res_next;

    // operand unpack
    logic [10:0]       ea, eb;
    logic [MANT_W-1:0] mant_a, mant_b;
    logic              sgn;

    // partial product
    logic [HALF_W-1:0]   px, py;
    logic [2*HALF_W-1:0] pp;
    logic [PROD_W-1:0]   pp_sh;

    // divide step
    logic              qbit;
    logic [REM_W-1:0]  rem_sub;

    // leading zero count
    logic [LZ_W-1:0]   lz_cnt;

    // round
    logic signed [EXP_W-1:0] e_norm, s_amt, r_amt;
    logic [PROD_W-1:0]       t, lost;
    logic                    sticky, rup;
    logic [REM_W-1:0]        mr;
    logic [12:0]             ebase;
    logic [DBL_W:0]          magw;
    logic [DBL_W-1:0]        rnd_res;

    assign done   = (state_reg == FS_DONE);
    assign result = res_reg;

    assign ea     = (a[62:52] == '0) ? 11'd1 : a[62:52];
    assign eb     = (b[62:52] == '0) ? 11'd1 : b[62:52];
    assign mant_a = {a[62:52] != '0, a[51:0]};
    assign mant_b = {b[62:52] != '0, b[51:0]};
    assign sgn    = a[63] ^ b[63];

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    begin px = {1'b0, ma_reg[25:0]}; py = {1'b0, mb_reg[25:0]}; end
            2'd1:    begin px = {1'b0, ma_reg[25:0]}; py = mb_reg[52:26];         end
            2'd2:    begin px = ma_reg[52:26];         py = {1'b0, mb_reg[25:0]}; end
            default: begin px = ma_reg[52:26];         py = mb_reg[52:26];         end
        endcase
        pp = px * py;
        case (cnt_reg[1:0])
            2'd0:    pp_sh = {52'b0, pp};
            2'd1,
            2'd2:    pp_sh = {26'b0, pp, 26'b0};
            default: pp_sh = {pp, 52'b0};
        endcase
    end

    assign qbit    = (rem_reg >= {1'b0, ma_reg});
    assign rem_sub = qbit ? (rem_reg - {1'b0, ma_reg}) : rem_reg;

    always_comb
    begin
        lz_cnt = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (prod_reg[i])
            begin
                lz_cnt = LZ_W'(PROD_W - 1 - i);
            end
        end
    end

    always_comb
    begin
        e_norm = esum_reg - 14'sd1022 - $signed({7'b0, lz_reg});
        if (e_norm >= 14'sd1)
        begin
            s_amt = $signed({7'b0, lz_reg});
        end
        else
        begin
            s_amt = $signed({7'b0, lz_reg}) - 14'sd1 + e_norm;
        end
        r_amt = -s_amt;
        lost  = '0;
        if (!s_amt[EXP_W-1])
        begin
            t = prod_reg << s_amt[LZ_W-1:0];
        end
        else if (r_amt > 14'sd105)
        begin
            t    = '0;
            lost = prod_reg;
        end
        else
        begin
            t    = prod_reg >> r_amt[LZ_W-1:0];
            lost = prod_reg & ~({PROD_W{1'b1}} << r_amt[LZ_W-1:0]);
        end
        sticky = (lost != '0) || (t[51:0] != '0) || stk_reg;
        rup    = t[52] & (sticky | t[53]);
        mr     = {1'b0, t[105:53]} + REM_W'(rup);
        ebase  = (e_norm >= 14'sd1) ? (e_norm[12:0] - 13'd1) : 13'd0;
        magw   = {ebase, 52'b0} + {11'b0, mr};
        if (magw >= {13'h7FF, 52'b0})
        begin
            rnd_res = {sign_reg, EXP_MAX, 52'b0};
        end
        else
        begin
            rnd_res = {sign_reg, magw[62:0]};
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        sign_next  = sign_reg;
        esum_next  = esum_reg;
        prod_next  = prod_reg;
        stk_next   = stk_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        rem_next   = rem_reg;
        lz_next    = lz_reg;
        res_next   = res_reg;
        case (state_reg)
            FS_IDLE:
            begin
                cnt_next  = '0;
                prod_next = '0;
                stk_next  = 1'b0;
                if (start && op == OP_MUL)
                begin
                    sign_next  = sgn;
                    ma_next    = mant_a;
                    mb_next    = mant_b;
                    esum_next  = $signed({3'b0, ea}) + $signed({3'b0, eb});
                    state_next = FS_DONE;
                    if (is_nan(a))
                    begin
                        res_next = a | (64'd1 << QUIET_BIT);
                    end
                    else if (is_nan(b))
                    begin
                        res_next = b | (64'd1 << QUIET_BIT);
                    end
                    else if ((is_inf(a) && is_zero(b)) || (is_zero(a) && is_inf(b)))
                    begin
                        res_next = DFLT_NAN;
                    end
                    else if (is_inf(a) || is_inf(b))
                    begin
                        res_next = {sgn, EXP_MAX, 52'b0};
                    end
                    else if (is_zero(a) || is_zero(b))
                    begin
                        res_next = {sgn, 63'b0};
                    end
                    else
                    begin
                        state_next = FS_PP;
                    end
                end
                else if (start)
                begin
                    sign_next  = a[63];
                    ma_next    = mant_a;
                    esum_next  = $signed({3'b0, ea});  // holds the divisor exponent
                    rem_next   = REM_W'(1) << FRAC_W;
                    state_next = FS_DONE;
                    if (is_nan(a))
                    begin
                        res_next = a | (64'd1 << QUIET_BIT);
                    end
                    else if (is_inf(a))
                    begin
                        res_next = {a[63], 63'b0};
                    end
                    else if (is_zero(a))
                    begin
                        res_next = {a[63], EXP_MAX, 52'b0};
                    end
                    else
                    begin
                        state_next = FS_DNORM;
                    end
                end
            end
            FS_PP:
            begin
                prod_next = prod_reg + pp_sh;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == PP_LAST)
                begin
                    state_next = FS_LZC;
                end
            end
            FS_DNORM:
            begin
                // bring a subnormal divisor up to a leading one
                if (ma_reg[MANT_W-1])
                begin
                    state_next = FS_DIV;
                end
                else
                begin
                    ma_next   = ma_reg << 1;
                    esum_next = esum_reg - 14'sd1;
                end
            end
            FS_DIV:
            begin
                rem_next  = rem_sub << 1;
                prod_next = {prod_reg[PROD_W-2:0], qbit};
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    stk_next   = (rem_sub != '0);
                    esum_next  = 14'sd3118 - esum_reg;
                    state_next = FS_LZC;
                end
            end
            FS_LZC:
            begin
                lz_next    = lz_cnt;
                state_next = FS_RND;
            end
            FS_RND:
            begin
                res_next   = rnd_res;
                state_next = FS_DONE;
            end
            FS_DONE:
            begin
                state_next = FS_IDLE;
            end
            default:
            begin
                state_next = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FS_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        esum_reg <= esum_next;
        prod_reg <= prod_next;
        stk_reg  <= stk_next;
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        rem_reg  <= rem_next;
        lz_reg   <= lz_next;
        res_reg  <= res_next;
    end

endmodule

// ----- rtl/core/ipd_dp.sv -----
// ----------------------------------------------------------------------------
// ipd_dp
// Datapath: exponent decode, base/accumulator/magnitude registers, the
// shared FP unit and the result register.
// ----------------------------------------------------------------------------
module ipd_dp
    import ipd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dp_cmd_t          cmd,
    input  logic [DBL_W-1:0] base_bits,
    input  logic [DBL_W-1:0] exponent_bits,
    output dp_status_t       status,
    output logic [DBL_W-1:0] power_bits
);

    logic [DBL_W-1:0] base_reg, base_next;
    logic [DBL_W-1:0] acc_reg, acc_next;
    logic [DBL_W-1:0] power_reg, power_next;
    logic [MAG_W-1:0] mag_reg, mag_next;
    logic             neg_reg, neg_next;
    logic             special_reg, special_next;

    // decode
    logic [10:0]       ee;
    logic [10:0]       n_full;
    logic [5:0]        rs;
    logic [MANT_W-1:0] m, q;
    logic              integral;
    logic              dec_special;
    logic [DBL_W-1:0]  dec_value;

    logic             fpu_done;
    logic [DBL_W-1:0] fpu_res;
    logic [DBL_W-1:0] fpu_a;

    assign ee       = exponent_bits[62:52];
    assign n_full   = ee - EXP_BIAS;
    assign rs       = 6'd52 - {1'b0, n_full[4:0]};
    assign m        = {1'b1, exponent_bits[51:0]};
    assign q        = m >> rs;
    assign integral = ((q << rs) == m);

    always_comb
    begin
        dec_special = 1'b1;
        dec_value   = base_bits;
        if (is_zero(exponent_bits))
        begin
            dec_value = ONE_BITS;
        end
        else if (is_zero(base_bits))
        begin
            dec_value = ZERO_BITS;
        end
        else if (ee >= EXP_LIMIT || ee < EXP_BIAS || !integral)
        begin
            dec_value = base_bits;   // NaN, huge or fractional: pass base
        end
        else
        begin
            dec_special = 1'b0;
            dec_value   = ONE_BITS;
        end
    end

    assign fpu_a = cmd.sel_sqr ? base_reg : acc_reg;

    ipd_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.fpu_start),
        .op     (cmd.fpu_op),
        .a      (fpu_a),
        .b      (base_reg),
        .done   (fpu_done),
        .result (fpu_res)
    );

    always_comb
    begin
        base_next    = base_reg;
        acc_next     = acc_reg;
        mag_next     = mag_reg;
        neg_next     = neg_reg;
        special_next = special_reg;
        power_next   = power_reg;
        if (cmd.load)
        begin
            base_next    = base_bits;
            acc_next     = dec_value;
            mag_next     = q[MAG_W-1:0];
            neg_next     = exponent_bits[63];
            special_next = dec_special;
        end
        if (cmd.wr_acc)
        begin
            acc_next = fpu_res;
        end
        if (cmd.wr_base)
        begin
            base_next = fpu_res;
        end
        if (cmd.shift_mag)
        begin
            mag_next = mag_reg >> 1;
        end
        if (cmd.out_load)
        begin
            power_next = acc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        acc_reg     <= acc_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        special_reg <= special_next;
        power_reg   <= power_next;
    end

    assign status.special  = special_reg;
    assign status.neg      = neg_reg;
    assign status.mag_zero = (mag_reg == '0);
    assign status.mag_bit0 = mag_reg[0];
    assign status.mag_last = (mag_reg[MAG_W-1:1] == '0);
    assign status.fpu_done = fpu_done;
    assign power_bits      = power_reg;

endmodule

// ----- rtl/core/ipd_ctrl.sv -----
// ----------------------------------------------------------------------------
// ipd_ctrl
// Sequencer for square-and-multiply, reciprocal and result hand-off.
// ----------------------------------------------------------------------------
module ipd_ctrl
    import ipd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.fpu_op     = OP_MUL;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                if (status.special)
                begin
                    state_next = ST_FINISH;
                end
                else if (status.mag_zero)
                begin
                    if (status.neg)
                    begin
                        cmd.fpu_start = 1'b1;
                        cmd.fpu_op    = OP_RECIP;
                        state_next    = ST_RECIP;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (status.mag_bit0)
                begin
                    cmd.fpu_start = 1'b1;
                    state_next    = ST_MUL;
                end
                else
                begin
                    state_next = ST_SQR_ISSUE;
                end
            end
            ST_MUL:
            begin
                if (status.fpu_done)
                begin
                    cmd.wr_acc = 1'b1;
                    state_next = ST_SQR_ISSUE;
                end
            end
            ST_SQR_ISSUE:
            begin
                // last bit: base no longer needed, skip the square
                if (status.mag_last)
                begin
                    cmd.shift_mag = 1'b1;
                    state_next    = ST_STEP;
                end
                else
                begin
                    cmd.fpu_start = 1'b1;
                    cmd.sel_sqr   = 1'b1;
                    state_next    = ST_SQR;
                end
            end
            ST_SQR:
            begin
                if (status.fpu_done)
                begin
                    cmd.wr_base   = 1'b1;
                    cmd.shift_mag = 1'b1;
                    state_next    = ST_STEP;
                end
            end
            ST_RECIP:
            begin
                if (status.fpu_done)
                begin
                    cmd.wr_acc = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/integer_power_double.sv -----
// ----------------------------------------------------------------------------
// integer_power_double
// Double base raised to an integral double exponent by square-and-multiply.
// ----------------------------------------------------------------------------
// Sequence after a word is accepted: a special case goes straight from STEP
// to FINISH; otherwise each exponent magnitude bit passes through STEP, a set
// bit adds a multiply and each bit but the top one a square, each holding the
// shared unit, and a negative exponent ends with the reciprocal (longer for a
// subnormal product).
// Throughput: one word at a time; a new word is taken the cycle after the
// previous result reaches the output register. Reset clears all control state.
// ----------------------------------------------------------------------------
module integer_power_double
    import ipd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [DBL_W-1:0] base_bits,
    input  logic [DBL_W-1:0] exponent_bits,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [DBL_W-1:0] power_bits
);

    // Flow: a word is taken in IDLE and decoded at once (zero exponent,
    // zero base, NaN / huge / fractional exponent pass straight to the
    // result). Otherwise the controller walks the exponent magnitude LSB
    // first: multiply accumulator by base on a set bit, then square base.
    // The square after the top bit is skipped since its value is unused.
    // A negative exponent ends with 1.0/acc through a restoring divider.
    // The FP unit is a 4-pass 27x27 multiplier feeding a registered
    // leading-zero count (LZC state) and a round stage that handles subnormals.

    dp_cmd_t    cmd;
    dp_status_t status;

    ipd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    ipd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .base_bits     (base_bits),
        .exponent_bits (exponent_bits),
        .status        (status),
        .power_bits    (power_bits)
    );

endmodule

// ----- rtl/core/ipd_chk.sv -----
// ----------------------------------------------------------------------------
// ipd_chk
// Port-level checks for the integer power unit.
// ----------------------------------------------------------------------------
module ipd_chk
    import ipd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [DBL_W-1:0] power_bits
);

    // a taken word makes the unit busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("not busy after accepting a word");

    // a result only appears at the end of a busy period
    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without work in flight");

    // going idle always leaves a result behind
    a_idle_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_stall) |-> out_valid)
        else $error("idle without result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(power_bits)))
        else $error("stalled result changed");

endmodule

bind integer_power_double ipd_chk u_chk (.*);
